// ----- rtl/pdrd_pkg.sv -----
package pdrd_pkg;

	localparam int DEF_MAX_FRAME_BITS = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_TIMEOUT = 3'd6;

	localparam logic [15:0] RST_GAP_MIN       = 16'd800;
	localparam logic [15:0] RST_GAP_MAX       = 16'd2600;
	localparam logic [15:0] RST_ONE_THRESHOLD = 16'd1600;
	localparam logic [15:0] RST_SYNC_MIN      = 16'd7000;
	localparam logic [5:0]  RST_FRAME_BITS    = 6'd20;
	localparam logic [19:0] RST_BURST_TIMEOUT = 20'd140000;

	localparam logic [31:0] MARK_MIN  = 32'd500;
	localparam logic [31:0] MARK_MAX  = 32'd650;
	localparam logic [5:0]  COUNT_SAT = 6'd63;
	localparam logic [6:0]  CHK_BIAS  = 7'h55;

	localparam logic MODE_X10 = 1'b0;
	localparam logic MODE_NEC = 1'b1;

	typedef struct packed {
		logic        pin_level;
		logic [31:0] time_us;
	} in_beat_t;

	typedef struct packed {
		logic        pulse_ok;
		logic        burst_start;
		logic        frame_ready;
		logic [31:0] frame_code;
		logic [15:0] address;
		logic [15:0] command;
		logic        frame_valid;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] address;
		logic [15:0] command;
		logic        frame_valid;
	} frame_info_t;

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[15-i] = v[i];
		end
		return r;
	endfunction

endpackage

// ----- rtl/pulse_distance_remote_decoder_top.sv -----
// Pulse-distance remote decoder (X10 / NEC style).
// Input channel: one beat per receiver edge (pin level after the edge and a
// wrapping microsecond timestamp), valid/stall handshake.
// Output channel: exactly one result beat per input beat, in order. Frame
// fields read zero unless frame_ready is set.
// Config port: cfg_we/cfg_addr/cfg_wdata, register index as listed in the
// register map; write only while no beats are in flight.
// A beat is taken into the input register and then decoded into the output
// register, where its result is shown. Throughput: one beat per cycle while
// the output is not stalled, set by the single decode stage between input
// register and output register.
// Stall: while the output register holds an untaken result, the stage
// behind it holds too; the input register takes one more beat only if it
// is empty, and raises in_stall while it holds a beat.
// Reset: all edge/frame state cleared, registers at their default values,
// both stages empty.
module pulse_distance_remote_decoder_top #(
	parameter int MAX_FRAME_BITS = pdrd_pkg::DEF_MAX_FRAME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pdrd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [pdrd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pdrd_pkg::in_beat_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pdrd_pkg::out_beat_t              out_data
);
	import pdrd_pkg::*;

	logic        mode_q;
	logic [15:0] gap_min_q;
	logic [15:0] gap_max_q;
	logic [15:0] one_thr_q;
	logic [15:0] sync_min_q;
	logic [5:0]  frame_bits_q;
	logic [19:0] burst_to_q;

	logic [31:0]               rise_q;
	logic [31:0]               prev_rise_q;
	logic [31:0]               last_frame_q;
	logic [MAX_FRAME_BITS-1:0] shift_q;
	logic [5:0]                count_q;

	in_beat_t  in_s1;
	logic      valid_s1;
	out_beat_t out_q;
	logic      out_valid_q;

	logic        advance;
	logic        active;
	logic [31:0] since_frame;
	logic [31:0] mark;
	logic [31:0] gap;
	logic        burst;
	logic        mark_ok;
	logic        is_bit;
	logic        is_sync;
	logic        one;
	logic        emit;
	logic [31:0] fcode;
	frame_info_t info;
	out_beat_t   result;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_X10;
			gap_min_q    <= RST_GAP_MIN;
			gap_max_q    <= RST_GAP_MAX;
			one_thr_q    <= RST_ONE_THRESHOLD;
			sync_min_q   <= RST_SYNC_MIN;
			frame_bits_q <= RST_FRAME_BITS;
			burst_to_q   <= RST_BURST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PROTOCOL_MODE: mode_q       <= cfg_wdata[0];
				REG_GAP_MIN:       gap_min_q    <= cfg_wdata[15:0];
				REG_GAP_MAX:       gap_max_q    <= cfg_wdata[15:0];
				REG_ONE_THRESHOLD: one_thr_q    <= cfg_wdata[15:0];
				REG_SYNC_MIN:      sync_min_q   <= cfg_wdata[15:0];
				REG_FRAME_BITS:    frame_bits_q <= cfg_wdata[5:0];
				REG_BURST_TIMEOUT: burst_to_q   <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	// edge classification, all durations mod 2^32
	assign active      = in_s1.pin_level ^ mode_q;
	assign since_frame = in_s1.time_us - last_frame_q;
	assign mark        = in_s1.time_us - rise_q;
	assign gap         = rise_q - prev_rise_q;
	assign burst       = active && (since_frame > {12'b0, burst_to_q});
	assign mark_ok     = !active && (mark > MARK_MIN) && (mark < MARK_MAX);
	assign is_bit      = (gap > {16'b0, gap_min_q}) && (gap < {16'b0, gap_max_q});
	assign is_sync     = !is_bit && (gap >= {16'b0, sync_min_q});
	assign one         = (mode_q == MODE_NEC) ? (gap < {16'b0, one_thr_q})
	                                          : (gap > {16'b0, one_thr_q});
	assign emit        = mark_ok && is_sync && (count_q == frame_bits_q);

	assign fcode = 32'(shift_q);

	pdrd_frame_decode u_decode (
		.mode (mode_q),
		.emit (emit),
		.code (fcode),
		.info (info)
	);

	always_comb begin
		result             = '0;
		result.pulse_ok    = mark_ok && (is_bit || emit);
		result.burst_start = burst;
		result.frame_ready = emit;
		result.frame_code  = emit ? fcode : 32'b0;
		result.address     = info.address;
		result.command     = info.command;
		result.frame_valid = info.frame_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q       <= '0;
			prev_rise_q  <= '0;
			last_frame_q <= '0;
			shift_q      <= '0;
			count_q      <= '0;
		end else if (advance) begin
			if (active) begin
				rise_q <= in_s1.time_us;
			end else if (mark_ok) begin
				prev_rise_q <= rise_q;
				if (is_bit) begin
					shift_q <= {shift_q[MAX_FRAME_BITS-2:0], one};
					if (count_q != COUNT_SAT) begin
						count_q <= count_q + 6'd1;
					end
				end else if (is_sync) begin
					if (emit) begin
						last_frame_q <= in_s1.time_us;
					end
					shift_q <= '0;
					count_q <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/pdrd_frame_decode.sv -----
module pdrd_frame_decode (
	input  logic                  mode,
	input  logic                  emit,
	input  logic [31:0]           code,
	output pdrd_pkg::frame_info_t info
);
	import pdrd_pkg::*;

	logic [3:0]  x10_addr;
	logic [6:0]  x10_cmd;
	logic [6:0]  x10_sum;
	logic [15:0] nec_addr;
	logic [15:0] nec_cmd;

	assign x10_addr = code[3:0];
	assign x10_cmd  = code[10:4];
	// 7-bit checksum: command + bias + low three address bits in the upper three bits, wrapped
	assign x10_sum  = 7'(x10_cmd + CHK_BIAS + {x10_addr[2:0], 4'b0000});

	assign nec_addr = rev16(code[31:16]);
	assign nec_cmd  = rev16(code[15:0]);

	always_comb begin
		info = '0;
		if (emit) begin
			if (mode == MODE_NEC) begin
				info.address     = nec_addr;
				info.command     = nec_cmd;
				info.frame_valid = (nec_cmd[7:0] == ~nec_cmd[15:8]);
			end else begin
				info.address     = {12'b0, x10_addr};
				info.command     = {9'b0, x10_cmd};
				info.frame_valid = (code[18:12] == x10_sum);
			end
		end
	end

endmodule

// ----- rtl/pdrd_checker.sv -----
module pdrd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input pdrd_pkg::out_beat_t out_data
);
	import pdrd_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// frame fields are zero without a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_ready |->
			out_data.frame_code == 32'b0 && out_data.address == 16'b0 &&
			out_data.command == 16'b0 && !out_data.frame_valid)
		else $error("frame fields set without frame_ready");

	// an emitted frame always counts as an accepted pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_ready |-> out_data.pulse_ok)
		else $error("frame emitted without pulse_ok");

	// burst start comes from active edges, pulses from inactive ones
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.burst_start |-> !out_data.pulse_ok)
		else $error("burst_start and pulse_ok on one edge");

endmodule

bind pulse_distance_remote_decoder_top pdrd_checker u_pdrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
